FILE: rtl/nfa_pkg.sv
// Shared types and constants for the next-fit identifier allocator.
`timescale 1ns / 1ps

package nfa_pkg;

	localparam int ID_BITS_DEF  = 16;
	localparam int PORT_ID_BITS = 16;
	localparam int WORD_LOG_MAX = 5;

	typedef logic [1:0] status_t;

	localparam status_t STS_OK     = 2'd0;
	localparam status_t STS_FULL   = 2'd1;
	localparam status_t STS_UNUSED = 2'd2;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REL,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

FILE: rtl/nfa_map_ram.sv
// Used-map storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module nfa_map_ram #(
	parameter int WORD_BITS = 32,
	parameter int ADDR_BITS = 11
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WORD_BITS-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/nfa_first_free.sv
// Lowest-set-bit finder over one used-map word.
`timescale 1ns / 1ps

module nfa_first_free #(
	parameter int WORD_BITS = 32,
	parameter int IDX_BITS  = 5
) (
	input  logic [WORD_BITS-1:0] free_word,
	output logic                 found,
	output logic [IDX_BITS-1:0]  idx
);

	assign found = |free_word;

	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_word[i]) begin
				idx = IDX_BITS'(i);
			end
		end
	end

endmodule

FILE: rtl/next_fit_id_allocator_core.sv
// Next-fit identifier allocator: used-map memory, cursor, in-use count, control.
// Release: read the map word, clear the bit in ST_REL, respond in ST_RESP. Allocate: scans
// k used-map words (one 32-bit word per cycle, read port bound), at most
// 2^(ID_BITS-5) + 1 words; allocate on a full pool skips the scan and goes to ST_RESP.
// Reset: async, active low; a clearing pass writes one map word per cycle over all
// 2^(ID_BITS-5) words (2048 at 16 bits), and in_stall stays high until it ends.
`timescale 1ns / 1ps

module next_fit_id_allocator_core #(
	parameter int ID_BITS = nfa_pkg::ID_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 operation,
	input  logic [nfa_pkg::PORT_ID_BITS-1:0]     release_id,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [nfa_pkg::PORT_ID_BITS-1:0]     granted_id,
	output nfa_pkg::status_t                     status,
	output logic [nfa_pkg::PORT_ID_BITS-1:0]     in_use_count
);

	import nfa_pkg::*;

	localparam int W_LOG     = (ID_BITS <= WORD_LOG_MAX) ? ID_BITS - 1 : WORD_LOG_MAX;
	localparam int WORD_BITS = 1 << W_LOG;
	localparam int ADDR_BITS = ID_BITS - W_LOG;
	localparam int CMP_BITS  = (ID_BITS > PORT_ID_BITS) ? ID_BITS : PORT_ID_BITS;
	localparam logic [ID_BITS-1:0] MAX_ID = '1;

	state_t state_q, state_d;

	logic [ADDR_BITS-1:0] clr_addr_q;
	logic [ID_BITS-1:0]   cursor_q;
	logic [ID_BITS-1:0]   count_q;
	logic                 out_valid_q;

	logic [ADDR_BITS-1:0] scan_addr_q;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 first_s1;
	logic [ID_BITS-1:0]   rid_q;
	logic                 rid_ok_q;
	logic [ID_BITS-1:0]   res_id_q;
	status_t              res_sts_q;
	logic [PORT_ID_BITS-1:0] granted_q;
	status_t                 status_q;
	logic [PORT_ID_BITS-1:0] count_out_q;

	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [ADDR_BITS-1:0] mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	logic                 accept;
	logic                 count_full;
	logic [ID_BITS-1:0]   rid_id;
	logic                 rid_ok;
	logic [ADDR_BITS-1:0] cur_word;
	logic [W_LOG-1:0]     cur_low;
	logic [WORD_BITS-1:0] scan_mask;
	logic [WORD_BITS-1:0] free_word;
	logic                 ff_found;
	logic [W_LOG-1:0]     ff_idx;
	logic [ID_BITS-1:0]   hit_id;
	logic [W_LOG-1:0]     rid_low;
	logic                 rel_hit;
	logic                 out_free;

	nfa_map_ram #(
		.WORD_BITS (WORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	nfa_first_free #(
		.WORD_BITS (WORD_BITS),
		.IDX_BITS  (W_LOG)
	) u_ff (
		.free_word (free_word),
		.found     (ff_found),
		.idx       (ff_idx)
	);

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign count_full = (count_q >= MAX_ID);
	assign rid_id     = ID_BITS'(release_id);
	assign rid_ok     = (release_id != '0) && (CMP_BITS'(release_id) <= CMP_BITS'(MAX_ID));
	assign cur_word   = cursor_q[ID_BITS-1:W_LOG];
	assign cur_low    = cursor_q[W_LOG-1:0];
	assign rid_low    = rid_q[W_LOG-1:0];
	assign rel_hit    = rid_ok_q && mem_rdata[rid_low];
	assign hit_id     = {addr_s1, ff_idx};
	assign out_free   = !out_valid_q || !out_stall;

	// identifier 0 is never handed out
	always_comb begin
		scan_mask = first_s1 ? ({WORD_BITS{1'b1}} << cur_low) : {WORD_BITS{1'b1}};
		if (addr_s1 == '0) begin
			scan_mask[0] = 1'b0;
		end
		free_word = ~mem_rdata & scan_mask;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == OP_RELEASE) begin
						state_d = ST_REL;
					end else if (count_full) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_REL: state_d = ST_RESP;
			ST_SCAN: begin
				if (ff_found) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = scan_addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				mem_re    = in_valid;
				mem_raddr = (operation == OP_RELEASE) ? rid_id[ID_BITS-1:W_LOG] : cur_word;
			end
			ST_REL: begin
				mem_we    = rel_hit;
				mem_waddr = rid_q[ID_BITS-1:W_LOG];
				mem_wdata = mem_rdata & ~(WORD_BITS'(1) << rid_low);
			end
			ST_SCAN: begin
				mem_re    = 1'b1;
				mem_we    = ff_found;
				mem_wdata = mem_rdata | (WORD_BITS'(1) << ff_idx);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			cursor_q    <= ID_BITS'(1);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_BITS'(1);
			end
			if (state_q == ST_REL && rel_hit && count_q != '0) begin
				count_q <= count_q - ID_BITS'(1);
			end
			if (state_q == ST_SCAN && ff_found) begin
				count_q  <= count_q + ID_BITS'(1);
				cursor_q <= hit_id;
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rid_q    <= rid_id;
			rid_ok_q <= rid_ok;
			scan_addr_q <= cur_word + ADDR_BITS'(1);
			addr_s1     <= cur_word;
			first_s1    <= 1'b1;
			res_id_q    <= '0;
			res_sts_q   <= STS_FULL;
		end
		if (state_q == ST_REL) begin
			res_id_q  <= '0;
			res_sts_q <= rel_hit ? STS_OK : STS_UNUSED;
		end
		if (state_q == ST_SCAN) begin
			scan_addr_q <= scan_addr_q + ADDR_BITS'(1);
			addr_s1     <= scan_addr_q;
			first_s1    <= 1'b0;
			if (ff_found) begin
				res_id_q  <= hit_id;
				res_sts_q <= STS_OK;
			end
		end
		if (state_q == ST_RESP && out_free) begin
			granted_q   <= PORT_ID_BITS'(res_id_q);
			status_q    <= res_sts_q;
			count_out_q <= PORT_ID_BITS'(count_q);
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign granted_id   = granted_q;
	assign status       = status_q;
	assign in_use_count = count_out_q;

endmodule

FILE: rtl/nfa_checker.sv
// Port-level checks for the next-fit identifier allocator, bound to the top level.
`timescale 1ns / 1ps

module nfa_checker #(
	parameter int ID_BITS = nfa_pkg::ID_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [nfa_pkg::PORT_ID_BITS-1:0] granted_id,
	input nfa_pkg::status_t                 status,
	input logic [nfa_pkg::PORT_ID_BITS-1:0] in_use_count
);

	import nfa_pkg::*;

	localparam logic [ID_BITS-1:0] MAX_ID = '1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_id) && $stable(status)
			&& $stable(in_use_count))
		else $error("result word changed while stalled");

	a_no_grant_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |-> granted_id == '0)
		else $error("nonzero id on an error result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_FULL |-> in_use_count == PORT_ID_BITS'(MAX_ID))
		else $error("pool full reported below capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("new word taken while one is in progress");

endmodule

bind next_fit_id_allocator_core nfa_checker #(.ID_BITS(ID_BITS)) u_nfa_checker (.*);

FILE: test/nfa_checker.sv
// Checker for the next-fit identifier allocator: predicts each grant word and compares it.
`timescale 1ns / 1ps

module nfa_grant_checker
	import nfa_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    operation,
	input  logic [PORT_ID_BITS-1:0] release_id,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [PORT_ID_BITS-1:0] granted_id,
	input  status_t                 status,
	input  logic [PORT_ID_BITS-1:0] in_use_count,
	output int                      fail_count,
	output int                      pending
);

	localparam int POOL_TOP = (1 << ID_BITS_DEF) - 1;

	typedef struct packed {
		logic [PORT_ID_BITS-1:0] id;
		status_t                 sts;
		logic [PORT_ID_BITS-1:0] count;
	} grant_t;

	bit     id_taken [0:POOL_TOP];
	int     cursor;
	int     taken_count;
	grant_t grants_owed[$];

	function automatic grant_t serve_word(input logic op, input logic [PORT_ID_BITS-1:0] rid);
		grant_t g;
		int     c;
		g.id  = '0;
		g.sts = STS_OK;
		if (op == OP_ALLOC) begin
			if (taken_count >= POOL_TOP) begin
				g.sts = STS_FULL;
			end else begin
				c = cursor;
				if (c == 0 || c > POOL_TOP)
					c = 1;
				for (int n = 0; n < POOL_TOP; n++) begin
					if (!id_taken[c])
						break;
					c = (c == POOL_TOP) ? 1 : c + 1;
				end
				if (id_taken[c]) begin
					g.sts = STS_FULL;
				end else begin
					id_taken[c] = 1'b1;
					taken_count++;
					cursor = c;
					g.id = PORT_ID_BITS'(c);
				end
			end
		end else begin
			if (rid != 0 && int'(rid) <= POOL_TOP && id_taken[rid]) begin
				id_taken[rid] = 1'b0;
				if (taken_count > 0)
					taken_count--;
			end else begin
				g.sts = STS_UNUSED;
			end
		end
		g.count = PORT_ID_BITS'(taken_count);
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (id_taken[i])
				id_taken[i] = 1'b0;
			cursor = 1;
			taken_count = 0;
			grants_owed.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (grants_owed.size() == 0) begin
					$error("grant word with nothing outstanding");
					fail_count++;
				end else begin
					want = grants_owed.pop_front();
					if (granted_id !== want.id) begin
						$error("granted_id: expected %0d, got %0d", want.id, granted_id);
						fail_count++;
					end
					if (status !== want.sts) begin
						$error("status: expected %0d, got %0d", want.sts, status);
						fail_count++;
					end
					if (in_use_count !== want.count) begin
						$error("in_use_count: expected %0d, got %0d", want.count, in_use_count);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				grants_owed.push_back(serve_word(operation, release_id));
			pending = grants_owed.size();
		end
	end

endmodule

FILE: test/testbench.sv
// Top of the allocator testbench: clock, reset, request and response drivers, verdict.
`timescale 1ns / 1ps

module testbench;
	import nfa_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 2100;
	localparam int PHASE_WORDS   = 85;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    operation = OP_ALLOC;
	logic [PORT_ID_BITS-1:0] release_id = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [PORT_ID_BITS-1:0] granted_id;
	status_t                 status;
	logic [PORT_ID_BITS-1:0] in_use_count;
	int                      fail_count;
	int                      pending;

	int send_idle_pct = 21;
	int recv_idle_pct = 67;
	bit hold_req = 1'b0;
	int allocs = 8;

	next_fit_id_allocator_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.release_id   (release_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_id   (granted_id),
		.status       (status),
		.in_use_count (in_use_count)
	);

	nfa_grant_checker grant_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.release_id   (release_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.granted_id   (granted_id),
		.status       (status),
		.in_use_count (in_use_count),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// response side; a hold request freezes it for a long stretch
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	initial begin
		int quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	task automatic send_word(input logic op, input logic [PORT_ID_BITS-1:0] rid);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		release_id = rid;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic random_word;
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			send_word(OP_ALLOC, PORT_ID_BITS'($urandom));
			allocs++;
		end else if (r < 90) begin
			send_word(OP_RELEASE, PORT_ID_BITS'($urandom_range(allocs + 4, 1)));
		end else begin
			send_word(OP_RELEASE, PORT_ID_BITS'($urandom));
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		send_word(OP_ALLOC, 16'hFFFF);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'h1234);
		send_word(OP_RELEASE, 16'd2);
		send_word(OP_RELEASE, 16'd2);
		send_word(OP_RELEASE, 16'd0);
		send_word(OP_RELEASE, 16'hFFFF);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_RELEASE, 16'd1);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_RELEASE, 16'd3);
		send_word(OP_RELEASE, 16'd4);
		send_word(OP_RELEASE, 16'd5);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_RELEASE, 16'h8000);
		send_word(OP_RELEASE, 16'h7FFF);
		send_word(OP_RELEASE, 16'h5555);
		send_word(OP_ALLOC, 16'hAAAA);
		send_word(OP_ALLOC, 16'h0000);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 67 : 0;
			recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 21 : 0;
			if (phase == 0)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (phase == 0 && i == 50)
					drain;
				random_word();
			end
		end

		// error probes and releases near the pool edges
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_RELEASE, 16'd0);
		send_word(OP_RELEASE, 16'hFFFF);
		send_word(OP_RELEASE, 16'd1);
		send_word(OP_RELEASE, 16'd40000);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_RELEASE, 16'hFFFF);
		send_word(OP_ALLOC, 16'h0000);
		send_word(OP_ALLOC, 16'h0000);

		drain;
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
